FILE: rtl/prl_pkg.sv
`default_nettype none

package prl_pkg;

   // Command codes
   localparam logic [2:0] CMD_APPEND    = 3'd0;
   localparam logic [2:0] CMD_READ      = 3'd1;
   localparam logic [2:0] CMD_INSERT    = 3'd2;
   localparam logic [2:0] CMD_DELETE    = 3'd3;
   localparam logic [2:0] CMD_CLEAR     = 3'd4;
   localparam logic [2:0] CMD_OVERWRITE = 3'd5;

   // Status codes
   localparam logic [1:0] ST_OK    = 2'd0;
   localparam logic [1:0] ST_RANGE = 2'd1;
   localparam logic [1:0] ST_FULL  = 2'd2;

   typedef struct packed {
      logic [2:0]  command;
      logic [6:0]  position;
      logic [31:0] record_handle;
   } req_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [31:0] handle_out;
      logic [6:0]  entry_total;
   } rsp_type;

   // Broadcast control for every cell of the chain
   typedef struct packed {
      logic ins;   // shift up above the position, load at it
      logic del;   // shift down from the position on
      logic wr;    // load at the position
      logic rd;    // drive the value at the position onto the read tap
   } cell_ctl_type;

endpackage

`default_nettype wire

FILE: rtl/prl_cell.sv
`default_nettype none

module prl_cell #(
   parameter int INDEX        = 0,
   parameter int CNT_W        = 7,
   parameter int HANDLE_WIDTH = 32
) (
   input  wire                        clock,
   input  prl_pkg::cell_ctl_type      ctl,
   input  wire [CNT_W-1:0]            sel_pos,
   input  wire [HANDLE_WIDTH-1:0]     handle,
   input  wire [HANDLE_WIDTH-1:0]     left_in,
   input  wire [HANDLE_WIDTH-1:0]     right_in,
   output logic [HANDLE_WIDTH-1:0]    value_out,
   output logic [HANDLE_WIDTH-1:0]    tap_out
);

   localparam logic [CNT_W-1:0] MY_INDEX = CNT_W'(INDEX);

   logic [HANDLE_WIDTH-1:0] value_ff;
   logic [HANDLE_WIDTH-1:0] value_in;
   logic                    at_pos;
   logic                    above_pos;

   assign at_pos    = (MY_INDEX == sel_pos);
   assign above_pos = (MY_INDEX > sel_pos);

   always_comb begin
      value_in = value_ff;
      if (ctl.ins) begin
         if (above_pos) begin
            value_in = left_in;
         end else if (at_pos) begin
            value_in = handle;
         end
      end else if (ctl.del) begin
         if (above_pos || at_pos) begin
            value_in = right_in;
         end
      end else if (ctl.wr && at_pos) begin
         value_in = handle;
      end
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
   end

   assign value_out = value_ff;
   assign tap_out   = (ctl.rd && at_pos) ? value_ff : '0;

endmodule

`default_nettype wire

FILE: rtl/positional_record_list_core.sv
// Channel   | Ports                      | Handshake
// ----------+----------------------------+-------------------------------------
// request   | start, busy, req_item      | item taken at edge with start & !busy
// result    | rsp_valid, rsp_item        | one-cycle strobe, no backpressure
//
// An accepted item is registered at the accept edge (busy rises); at the
// following edge the chain cells shift or load in parallel and the result
// is registered, and busy falls. No new item is accepted while busy.
// Reset clears the entry count and the control flags; cell contents stay
// stale and are never read before being written.
// The result strobe cannot be stalled: the receiver must take it when shown.
`default_nettype none

module positional_record_list_core #(
   parameter int DEPTH        = 64,
   parameter int HANDLE_WIDTH = 32
) (
   input  wire              clock,
   input  wire              reset,
   input  wire              start,
   output logic             busy,
   input  prl_pkg::req_type req_item,
   output logic             rsp_valid,
   output prl_pkg::rsp_type rsp_item
);

   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam int CMP_W = (CNT_W > 7) ? CNT_W : 7;
   localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(DEPTH);

   // Request register and pending flag
   prl_pkg::req_type      req_ff;
   prl_pkg::req_type      req_in;
   logic                  pend_ff;
   logic                  pend_in;

   // Entry count
   logic [CNT_W-1:0]      cnt_ff;
   logic [CNT_W-1:0]      cnt_in;

   // Result register
   prl_pkg::rsp_type      rsp_ff;
   prl_pkg::rsp_type      rsp_in;
   logic                  rsp_valid_ff;
   logic                  rsp_valid_in;

   // Execute-stage decode
   prl_pkg::cell_ctl_type ctl;
   logic [CNT_W-1:0]      sel_pos;
   logic [CMP_W-1:0]      pos_w;
   logic [CMP_W-1:0]      cnt_w;
   logic                  full;
   logic [1:0]            status;
   logic                  take_handle;
   logic [HANDLE_WIDTH-1:0] handle;
   logic [HANDLE_WIDTH-1:0] rd_data;
   logic [63:0]             rd_wide;

   // Chain wiring
   logic [HANDLE_WIDTH-1:0] vals [DEPTH];
   logic [HANDLE_WIDTH-1:0] taps [DEPTH];

   assign busy    = pend_ff;
   assign pend_in = start && !pend_ff;
   assign req_in  = (start && !pend_ff) ? req_item : req_ff;

   assign pos_w   = CMP_W'(req_ff.position);
   assign cnt_w   = CMP_W'(cnt_ff);
   assign full    = (cnt_ff == FULL_COUNT);
   assign handle  = HANDLE_WIDTH'(64'(req_ff.record_handle));
   // Append targets the cell just past the last entry
   assign sel_pos = (req_ff.command == prl_pkg::CMD_APPEND) ? cnt_ff : pos_w[CNT_W-1:0];

   // Decode the pending item into cell control, status and new count
   always_comb begin
      ctl         = '0;
      status      = prl_pkg::ST_OK;
      cnt_in      = cnt_ff;
      take_handle = 1'b0;
      if (pend_ff) begin
         unique case (req_ff.command)
            prl_pkg::CMD_APPEND: begin
               if (full) begin
                  status = prl_pkg::ST_FULL;
               end else begin
                  ctl.wr = 1'b1;
                  cnt_in = cnt_ff + 1'b1;
               end
            end
            prl_pkg::CMD_READ: begin
               if (pos_w >= cnt_w) begin
                  status = prl_pkg::ST_RANGE;
               end else begin
                  ctl.rd      = 1'b1;
                  take_handle = 1'b1;
               end
            end
            prl_pkg::CMD_INSERT: begin
               if (pos_w > cnt_w) begin
                  status = prl_pkg::ST_RANGE;
               end else if (full) begin
                  status = prl_pkg::ST_FULL;
               end else begin
                  ctl.ins = 1'b1;
                  cnt_in  = cnt_ff + 1'b1;
               end
            end
            prl_pkg::CMD_DELETE: begin
               if (pos_w >= cnt_w) begin
                  status = prl_pkg::ST_RANGE;
               end else begin
                  ctl.del     = 1'b1;
                  ctl.rd      = 1'b1;
                  take_handle = 1'b1;
                  cnt_in      = cnt_ff - 1'b1;
               end
            end
            prl_pkg::CMD_CLEAR: begin
               cnt_in = '0;
            end
            prl_pkg::CMD_OVERWRITE: begin
               if (pos_w >= cnt_w) begin
                  status = prl_pkg::ST_RANGE;
               end else begin
                  ctl.wr = 1'b1;
               end
            end
            default: begin
               // unused codes: no effect
            end
         endcase
      end
   end

   // Chain of cells: each sees its neighbors (the tail sees itself on the right), the head takes the new handle
   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      logic [HANDLE_WIDTH-1:0] left_val;
      logic [HANDLE_WIDTH-1:0] right_val;

      if (i == 0) begin : g_head
         assign left_val = handle;
      end else begin : g_body
         assign left_val = vals[i-1];
      end
      if (i == DEPTH - 1) begin : g_tail
         assign right_val = vals[i];
      end else begin : g_inner
         assign right_val = vals[i+1];
      end

      prl_cell #(
         .INDEX        (i),
         .CNT_W        (CNT_W),
         .HANDLE_WIDTH (HANDLE_WIDTH)
      ) u_cell (
         .clock     (clock),
         .ctl       (ctl),
         .sel_pos   (sel_pos),
         .handle    (handle),
         .left_in   (left_val),
         .right_in  (right_val),
         .value_out (vals[i]),
         .tap_out   (taps[i])
      );
   end

   // Merge read taps: at most one cell drives a nonzero tap
   always_comb begin
      rd_data = '0;
      for (int i = 0; i < DEPTH; i++) begin
         rd_data = rd_data | taps[i];
      end
   end

   assign rd_wide = 64'(rd_data);

   always_comb begin
      rsp_in.status      = status;
      rsp_in.handle_out  = take_handle ? rd_wide[31:0] : 32'd0;
      rsp_in.entry_total = 7'(cnt_in);
   end

   assign rsp_valid_in = pend_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff      <= 1'b0;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         pend_ff      <= pend_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Hold payload registers; advance only on accept or execute
   always_ff @(posedge clock) begin
      req_ff <= req_in;
      if (pend_ff) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_ff;

   // A result strobe is always preceded by an executing cycle
   a_rsp_after_exec: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> $past(pend_ff))
      else $error("result strobe without executed item");

   // An accepted item makes the block busy next cycle
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (start && !pend_ff) |=> pend_ff)
      else $error("accepted item not pending");

   // The count never passes the capacity
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= FULL_COUNT)
      else $error("entry count beyond capacity");

   // An error result carries no handle
   a_err_no_handle: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_ff.status != prl_pkg::ST_OK) |-> (rsp_ff.handle_out == 32'd0))
      else $error("error result with nonzero handle");

   // The count changes only while an item executes
   a_count_stable: assert property (@(posedge clock) disable iff (reset)
      !pend_ff |=> $stable(cnt_ff))
      else $error("entry count moved while idle");

endmodule

`default_nettype wire
